>>> hdl/ihbc_pkg.sv
`timescale 1ns / 1ps

package ihbc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int EPS_BITS = 23;
  localparam int REG_BITS = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CMP_BITS = ((SAMPLE_BITS > EPS_BITS) ? SAMPLE_BITS : EPS_BITS) + 2;
  localparam int SQ_BITS = 2 * SAMPLE_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_A_SQUARED = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_B_SQUARED = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTER_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURRENT_HYSTERESIS = 3'd4;

  localparam logic [REG_BITS-1:0] RST_INV_A_SQUARED = 32'd2912711;
  localparam logic [REG_BITS-1:0] RST_INV_B_SQUARED = 32'd459957207;
  localparam logic [REG_BITS-1:0] RST_INNER_LIMIT = 32'd16609443;
  localparam logic [REG_BITS-1:0] RST_OUTER_LIMIT = 32'd18454938;
  localparam logic [EPS_BITS-1:0] RST_CURRENT_HYSTERESIS = 23'd10;

  localparam logic signed [1:0] MODE_POS = 2'sb01;
  localparam logic signed [1:0] MODE_OFF = 2'sb00;
  localparam logic signed [1:0] MODE_NEG = 2'sb11;

  typedef enum logic [2:0] {
    RULE_NONE       = 3'd0,
    RULE_POS_TO_NEG = 3'd1,
    RULE_NEG_TO_POS = 3'd2,
    RULE_INNER_POS  = 3'd3,
    RULE_INNER_NEG  = 3'd4,
    RULE_OFF_V_NEG  = 3'd5,
    RULE_OFF_V_POS  = 3'd6
  } rule_t;

  typedef struct packed {
    logic [REG_BITS-1:0] inv_a_squared;
    logic [REG_BITS-1:0] inv_b_squared;
    logic [REG_BITS-1:0] inner_limit;
    logic [REG_BITS-1:0] outer_limit;
    logic [EPS_BITS-1:0] current_hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mag_v;
    logic [SAMPLE_BITS-1:0] mag_i;
    logic v_neg;
    logic v_zero;
    logic i_neg;
    logic i_zero;
    logic i_gt_eps;
    logic i_lt_neg_eps;
    logic i_le_eps;
    logic i_ge_neg_eps;
  } cls_t;

endpackage

>>> hdl/ihbc_front.sv
`timescale 1ns / 1ps

module ihbc_front (
  input  logic signed [ihbc_pkg::SAMPLE_BITS-1:0] sample_voltage,
  input  logic signed [ihbc_pkg::SAMPLE_BITS-1:0] sample_current,
  input  logic [ihbc_pkg::EPS_BITS-1:0]           eps,
  output ihbc_pkg::cls_t                          cls
);
  import ihbc_pkg::*;

  logic signed [CMP_BITS-1:0] i_ext;
  logic signed [CMP_BITS-1:0] eps_ext;
  logic signed [CMP_BITS-1:0] neg_eps;

  assign i_ext = CMP_BITS'(sample_current);
  assign eps_ext = $signed(CMP_BITS'(eps));
  assign neg_eps = -eps_ext;

  always_comb begin
    cls.v_neg = sample_voltage[SAMPLE_BITS-1];
    cls.v_zero = (sample_voltage == '0);
    cls.i_neg = sample_current[SAMPLE_BITS-1];
    cls.i_zero = (sample_current == '0);
    cls.mag_v = cls.v_neg ? (~sample_voltage + 1'b1) : sample_voltage;
    cls.mag_i = cls.i_neg ? (~sample_current + 1'b1) : sample_current;
    cls.i_gt_eps = (i_ext > eps_ext);
    cls.i_le_eps = (i_ext <= eps_ext);
    cls.i_lt_neg_eps = (i_ext < neg_eps);
    cls.i_ge_neg_eps = (i_ext >= neg_eps);
  end

endmodule

>>> hdl/ihbc_queue.sv
`timescale 1ns / 1ps

module ihbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ihbc_pkg::cls_t wr_data,
  input  logic           rd_en,
  output ihbc_pkg::cls_t rd_data,
  output logic           full,
  output logic           empty
);
  import ihbc_pkg::*;

  cls_t                   entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;

  assign full = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count <= QCOUNT_BITS'(QUEUE_DEPTH)) && !(wr_en && full && !rd_en))
    else $error("classification queue overflow");

endmodule

>>> hdl/ihbc_back.sv
`timescale 1ns / 1ps

module ihbc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  ihbc_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  ihbc_pkg::cls_t                  q_head,
  output logic                            q_pop,
  output logic signed [1:0]               switch_mode,
  output logic [ihbc_pkg::REG_BITS-1:0]   tracking_error,
  output logic [2:0]                      rule_fired,
  output logic                            empty,
  input  logic                            pop
);
  import ihbc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_HI, S_LO, S_SUM, S_DEC} state_t;

  state_t            state;
  cls_t              cls;
  logic [63:0]       sq_i;
  logic [63:0]       sq_v;
  logic [63:0]       ph_i;
  logic [63:0]       ph_v;
  logic [63:0]       pl_i;
  logic [63:0]       pl_v;
  logic [63:0]       term_i;
  logic [63:0]       term_v;
  logic signed [1:0] mode;
  logic              out_valid;

  logic [SQ_BITS-1:0]  sqp_i;
  logic [SQ_BITS-1:0]  sqp_v;
  logic [63:0]         mul_i;
  logic [63:0]         mul_v;
  logic [63:0]         sum;
  logic [REG_BITS-1:0] err;
  logic                above;
  logic                below;
  logic                i_nonneg;
  logic                i_nonpos;
  logic                v_nonpos;
  logic                v_pos;
  logic signed [1:0]   mode_next;
  rule_t               rule_next;
  logic                out_load;

  assign sqp_i = SQ_BITS'(q_head.mag_i) * SQ_BITS'(q_head.mag_i);
  assign sqp_v = SQ_BITS'(q_head.mag_v) * SQ_BITS'(q_head.mag_v);
  assign mul_i = 64'((state == S_HI) ? sq_i[63:32] : sq_i[31:0]) * 64'(cfg.inv_a_squared);
  assign mul_v = 64'((state == S_HI) ? sq_v[63:32] : sq_v[31:0]) * 64'(cfg.inv_b_squared);

  assign sum = term_i + term_v;
  assign err = (sum[63:32] != '0) ? '1 : sum[31:0];
  assign above = (err >= cfg.outer_limit);
  assign below = (err <= cfg.inner_limit);
  assign i_nonneg = !cls.i_neg;
  assign i_nonpos = cls.i_neg || cls.i_zero;
  assign v_nonpos = cls.v_neg || cls.v_zero;
  assign v_pos = !v_nonpos;

  always_comb begin
    mode_next = mode;
    rule_next = RULE_NONE;
    if (above && ((cls.i_gt_eps && cls.v_neg) || (i_nonneg && !cls.v_neg))
        && (mode == MODE_POS)) begin
      mode_next = MODE_NEG;
      rule_next = RULE_POS_TO_NEG;
    end else if (above && ((cls.i_lt_neg_eps && v_pos) || (i_nonpos && v_nonpos))
        && (mode == MODE_NEG)) begin
      mode_next = MODE_POS;
      rule_next = RULE_NEG_TO_POS;
    end else if (below && i_nonneg) begin
      mode_next = MODE_POS;
      rule_next = RULE_INNER_POS;
    end else if (below && i_nonpos) begin
      mode_next = MODE_NEG;
      rule_next = RULE_INNER_NEG;
    end else if (above && i_nonneg && cls.i_le_eps && cls.v_neg && (mode != MODE_OFF)) begin
      mode_next = MODE_OFF;
      rule_next = RULE_OFF_V_NEG;
    end else if (above && i_nonpos && cls.i_ge_neg_eps && v_pos && (mode != MODE_OFF)) begin
      mode_next = MODE_OFF;
      rule_next = RULE_OFF_V_POS;
    end
  end

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_DEC) && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_POS;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cls <= q_head;
            sq_i <= 64'(sqp_i);
            sq_v <= 64'(sqp_v);
            state <= S_HI;
          end
        end
        S_HI: begin
          ph_i <= mul_i;
          ph_v <= mul_v;
          state <= S_LO;
        end
        S_LO: begin
          pl_i <= mul_i;
          pl_v <= mul_v;
          state <= S_SUM;
        end
        S_SUM: begin
          term_i <= ph_i + {32'b0, pl_i[63:32]};
          term_v <= ph_v + {32'b0, pl_v[63:32]};
          state <= S_DEC;
        end
        S_DEC: begin
          if (out_load) begin
            mode <= mode_next;
            switch_mode <= mode_next;
            tracking_error <= err;
            rule_fired <= rule_next;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_POS) || (mode == MODE_NEG) || (mode == MODE_OFF))
    else $error("stored mode holds an illegal code");

  a_none_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    (out_load && (rule_next == RULE_NONE)) |=> $stable(mode))
    else $error("mode changed although no rule fired");

  a_inner_rules_below: assert property (@(posedge clk) disable iff (rst)
    (out_load && ((rule_next == RULE_INNER_POS) || (rule_next == RULE_INNER_NEG)))
    |=> (tracking_error <= cfg.inner_limit))
    else $error("inner band rule fired outside the inner band");

endmodule

>>> hdl/inverter_hybrid_band_control.sv
`timescale 1ns / 1ps

// Hybrid hysteresis band controller for a single-phase inverter. Each transfer
// on the push side carries one voltage and current sample; one result with the
// new bridge mode, the saturated tracking error and the rule that fired comes
// out on the pop side for each. Samples are classified on entry and wait in a
// two-entry queue, so up to four items can be taken before full rises while
// results are not popped. The back end takes one item at a time in five steps:
// the squares are formed as an item leaves the queue, its two 32-bit
// multipliers, one for current and one for voltage, then form the two partial
// products, followed by a sum step and a decision step that waits only if the
// previous result is still unread. Configuration is always ready and takes
// effect at once; write it only while the block is idle.

module inverter_hybrid_band_control (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [ihbc_pkg::SAMPLE_BITS-1:0] sample_voltage,
  input  logic signed [ihbc_pkg::SAMPLE_BITS-1:0] sample_current,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [1:0]                       switch_mode,
  output logic [ihbc_pkg::REG_BITS-1:0]           tracking_error,
  output logic [2:0]                              rule_fired,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ihbc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [ihbc_pkg::REG_BITS-1:0]           cfg_data
);
  import ihbc_pkg::*;

  cfg_t cfg;
  cls_t cls_in;
  cls_t q_head;
  logic q_empty;
  logic q_pop;
  logic q_push;

  assign cfg_ready = 1'b1;
  assign q_push = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_a_squared <= RST_INV_A_SQUARED;
      cfg.inv_b_squared <= RST_INV_B_SQUARED;
      cfg.inner_limit <= RST_INNER_LIMIT;
      cfg.outer_limit <= RST_OUTER_LIMIT;
      cfg.current_hysteresis <= RST_CURRENT_HYSTERESIS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INV_A_SQUARED: begin
          cfg.inv_a_squared <= cfg_data;
        end
        REG_INV_B_SQUARED: begin
          cfg.inv_b_squared <= cfg_data;
        end
        REG_INNER_LIMIT: begin
          cfg.inner_limit <= cfg_data;
        end
        REG_OUTER_LIMIT: begin
          cfg.outer_limit <= cfg_data;
        end
        REG_CURRENT_HYSTERESIS: begin
          cfg.current_hysteresis <= cfg_data[EPS_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ihbc_front u_front (
    .sample_voltage (sample_voltage),
    .sample_current (sample_current),
    .eps            (cfg.current_hysteresis),
    .cls            (cls_in)
  );

  ihbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (cls_in),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  ihbc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .switch_mode    (switch_mode),
    .tracking_error (tracking_error),
    .rule_fired     (rule_fired),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

>>> sim/tb_inverter_hybrid_band_control.sv
`timescale 1ns / 1ps

module tb_inverter_hybrid_band_control;
  import ihbc_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [REG_BITS-1:0] ERR_MAX = '1;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 142;
  localparam int HOLD_OFF_PHASE = 2;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;

  typedef struct packed {
    logic signed [1:0]   mode;
    logic [REG_BITS-1:0] err;
    logic [2:0]          rule;
  } band_result_t;

  typedef struct {
    int                            setting;
    logic signed [SAMPLE_BITS-1:0] v;
    logic signed [SAMPLE_BITS-1:0] i;
    bit                            pinned;
    band_result_t                  want;
  } directed_row_t;

  localparam band_result_t UNPINNED = '0;
  localparam cfg_t RESET_SETTING = '{RST_INV_A_SQUARED, RST_INV_B_SQUARED, RST_INNER_LIMIT,
                                     RST_OUTER_LIMIT, RST_CURRENT_HYSTERESIS};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] sample_voltage = '0;
  logic signed [SAMPLE_BITS-1:0] sample_current = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [1:0]             switch_mode;
  logic [REG_BITS-1:0]           tracking_error;
  logic [2:0]                    rule_fired;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [REG_BITS-1:0]           cfg_data = '0;

  cfg_t              band_cfg = RESET_SETTING;
  logic signed [1:0] tracked_mode = MODE_POS;
  band_result_t      pending_results[$];
  directed_row_t     directed_rows[25];
  cfg_t              directed_settings[4];
  int                burst_left = 0;
  int                mismatches = 0;
  int                samples_sent = 0;
  int                results_checked = 0;
  int                settings_applied = 0;
  int                rule_hits[8];
  bit                hold_off_req = 1'b0;

  inverter_hybrid_band_control u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_voltage(sample_voltage),
    .sample_current(sample_current),
    .empty         (empty),
    .pop           (pop),
    .switch_mode   (switch_mode),
    .tracking_error(tracking_error),
    .rule_fired    (rule_fired),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Each product is truncated to Q8.24 on its own before the two are added.
  function automatic logic [63:0] weighted_square(input longint mag, input logic [31:0] coef);
    logic [127:0] prod;
    prod = 128'(mag) * 128'(mag) * 128'(coef);
    return 64'(prod >> 32);
  endfunction

  function automatic band_result_t predict_band(input logic signed [SAMPLE_BITS-1:0] v_s,
                                                input logic signed [SAMPLE_BITS-1:0] i_s);
    longint       v;
    longint       i;
    longint       eps;
    logic [63:0]  e;
    logic         above;
    logic         below;
    band_result_t r;
    v = longint'(v_s);
    i = longint'(i_s);
    eps = longint'(band_cfg.current_hysteresis);
    e = weighted_square((i < 0) ? -i : i, band_cfg.inv_a_squared)
      + weighted_square((v < 0) ? -v : v, band_cfg.inv_b_squared);
    if (e > 64'(ERR_MAX)) e = 64'(ERR_MAX);
    above = e >= 64'(band_cfg.outer_limit);
    below = e <= 64'(band_cfg.inner_limit);
    r.mode = tracked_mode;
    r.rule = RULE_NONE;
    r.err = e[REG_BITS-1:0];
    if (above && ((i > eps && v < 0) || (i >= 0 && v >= 0)) && tracked_mode == MODE_POS) begin
      r.mode = MODE_NEG;
      r.rule = RULE_POS_TO_NEG;
    end else if (above && ((i < -eps && v > 0) || (i <= 0 && v <= 0))
                 && tracked_mode == MODE_NEG) begin
      r.mode = MODE_POS;
      r.rule = RULE_NEG_TO_POS;
    end else if (below && i >= 0) begin
      r.mode = MODE_POS;
      r.rule = RULE_INNER_POS;
    end else if (below && i <= 0) begin
      r.mode = MODE_NEG;
      r.rule = RULE_INNER_NEG;
    end else if (above && i >= 0 && i <= eps && v < 0 && tracked_mode != MODE_OFF) begin
      r.mode = MODE_OFF;
      r.rule = RULE_OFF_V_NEG;
    end else if (above && i <= 0 && i >= -eps && v > 0 && tracked_mode != MODE_OFF) begin
      r.mode = MODE_OFF;
      r.rule = RULE_OFF_V_POS;
    end
    tracked_mode = r.mode;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample(input logic [EPS_BITS-1:0] hyst);
    int                            d;
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: s = SAMPLE_MIN;
          1: s = SAMPLE_MAX;
          2: s = '0;
          3: s = SAMPLE_BITS'(1);
          default: s = '1;
        endcase
      end
      1: begin
        // Land on or next to the hysteresis edge, either sign.
        d = int'(hyst) + int'($urandom_range(0, 4)) - 2;
        if (d > int'(SAMPLE_MAX)) d = int'(SAMPLE_MAX);
        s = $urandom_range(0, 1) ? SAMPLE_BITS'(d) : SAMPLE_BITS'(-d);
      end
      default: s = $signed(SAMPLE_BITS'($urandom())) >>> $urandom_range(0, SAMPLE_BITS - 1);
    endcase
    return s;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.inv_a_squared = $urandom() >> $urandom_range(0, 31);
    s.inv_b_squared = $urandom() >> $urandom_range(0, 31);
    s.inner_limit = $urandom() >> $urandom_range(0, 31);
    s.outer_limit = $urandom() >> $urandom_range(0, 31);
    s.current_hysteresis = EPS_BITS'($urandom() >> $urandom_range(9, 31));
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INV_A_SQUARED:      band_cfg.inv_a_squared = data;
      REG_INV_B_SQUARED:      band_cfg.inv_b_squared = data;
      REG_INNER_LIMIT:        band_cfg.inner_limit = data;
      REG_OUTER_LIMIT:        band_cfg.outer_limit = data;
      REG_CURRENT_HYSTERESIS: band_cfg.current_hysteresis = data[EPS_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t s);
    int k;
    write_reg(REG_INV_A_SQUARED, s.inv_a_squared);
    write_reg(REG_INV_B_SQUARED, s.inv_b_squared);
    for (k = REG_CURRENT_HYSTERESIS + 1; k < 2 ** CFG_INDEX_BITS; k++) begin
      write_reg(CFG_INDEX_BITS'(k), $urandom());
    end
    write_reg(REG_INNER_LIMIT, s.inner_limit);
    write_reg(REG_OUTER_LIMIT, s.outer_limit);
    write_reg(REG_CURRENT_HYSTERESIS, {9'($urandom()), s.current_hysteresis});
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic settle_block();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v,
                             input logic signed [SAMPLE_BITS-1:0] i,
                             input bit pinned, input band_result_t want);
    int           gap;
    band_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    sample_voltage <= v;
    sample_current <= i;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predicted = predict_band(v, i);
    pending_results.push_back(pinned ? want : predicted);
    samples_sent++;
  endtask

  always @(posedge clk) begin : result_check
    band_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        rule_hits[want.rule]++;
        if (switch_mode !== want.mode)
          report_mismatch($sformatf("switch_mode %0d, expected %0d", switch_mode, want.mode));
        if (tracking_error !== want.err)
          report_mismatch($sformatf("tracking_error %h, expected %h", tracking_error, want.err));
        if (rule_fired !== want.rule)
          report_mismatch($sformatf("rule_fired %0d, expected %0d", rule_fired, want.rule));
      end
    end
  end

  initial begin : result_drain
    int run_len;
    int style;
    int hold_count;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        run_len = $urandom_range(1, 40);
        repeat (run_len) begin
          case (style)
            0, 1: pop <= 1'b1;
            2: pop <= 1'($urandom_range(0, 1));
            default: pop <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : timeout
    #5_000_000;
    $display("tb_inverter_hybrid_band_control failed");
    $finish;
  end

  initial begin : stimulus
    int current_setting;
    int phase;
    int n;
    int drain_cycles;
    logic signed [SAMPLE_BITS-1:0] v;

    directed_settings[0] = RESET_SETTING;
    directed_settings[1] = '{32'h0001_0000, 32'h0001_0000, 32'd1, 32'd1, '1};
    directed_settings[2] = '0;
    directed_settings[3] = '1;

    directed_rows = '{
      '{0, 24'sd0,    24'sd0,    1'b1, '{MODE_POS, 32'd0,   RULE_INNER_POS}},
      '{0, 24'sd0,    -24'sd1,   1'b1, '{MODE_NEG, 32'd0,   RULE_INNER_NEG}},
      '{0, 24'sd0,    24'sd0,    1'b1, '{MODE_POS, 32'd0,   RULE_INNER_POS}},
      '{0, SAMPLE_MIN, SAMPLE_MIN, 1'b1, '{MODE_POS, ERR_MAX, RULE_NONE}},
      '{0, SAMPLE_MAX, SAMPLE_MAX, 1'b1, '{MODE_NEG, ERR_MAX, RULE_POS_TO_NEG}},
      '{0, SAMPLE_MIN, SAMPLE_MIN, 1'b1, '{MODE_POS, ERR_MAX, RULE_NEG_TO_POS}},
      '{0, SAMPLE_MIN, 24'sd5,   1'b1, '{MODE_OFF, ERR_MAX, RULE_OFF_V_NEG}},
      '{0, SAMPLE_MAX, -24'sd5,  1'b1, '{MODE_OFF, ERR_MAX, RULE_NONE}},
      '{0, 24'sd0,    24'sd0,    1'b1, '{MODE_POS, 32'd0,   RULE_INNER_POS}},
      '{0, SAMPLE_MAX, -24'sd5,  1'b1, '{MODE_OFF, ERR_MAX, RULE_OFF_V_POS}},
      '{0, SAMPLE_MAX, -24'sd11, 1'b1, '{MODE_OFF, ERR_MAX, RULE_NONE}},
      '{0, 24'sd0,    24'sd0,    1'b1, '{MODE_POS, 32'd0,   RULE_INNER_POS}},
      '{0, SAMPLE_MIN, 24'sd11,  1'b0, UNPINNED},
      '{0, SAMPLE_MAX, -24'sd11, 1'b0, UNPINNED},
      '{0, SAMPLE_MAX, -24'sd10, 1'b0, UNPINNED},
      '{1, 24'sd0,    24'sd256,  1'b0, UNPINNED},
      '{1, 24'sd0,    -24'sd256, 1'b0, UNPINNED},
      '{1, 24'sd255,  24'sd255,  1'b0, UNPINNED},
      '{1, -24'sd4096, 24'sd100, 1'b0, UNPINNED},
      '{1, 24'sd4096, -24'sd100, 1'b0, UNPINNED},
      '{2, 24'sd0,    24'sd0,    1'b0, UNPINNED},
      '{2, -24'sd1,   24'sd1,    1'b0, UNPINNED},
      '{2, 24'sd0,    24'sd0,    1'b0, UNPINNED},
      '{3, SAMPLE_MIN, SAMPLE_MAX, 1'b0, UNPINNED},
      '{3, SAMPLE_MAX, SAMPLE_MIN, 1'b0, UNPINNED}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    current_setting = 0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].setting != current_setting) begin
        settle_block();
        current_setting = directed_rows[r].setting;
        apply_setting(directed_settings[current_setting]);
      end
      send_sample(directed_rows[r].v, directed_rows[r].i, directed_rows[r].pinned,
                  directed_rows[r].want);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      apply_setting((phase == 0) ? RESET_SETTING : random_setting());
      if (phase == HOLD_OFF_PHASE) hold_off_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        v = random_sample(band_cfg.current_hysteresis);
        send_sample(v, random_sample(band_cfg.current_hysteresis), 1'b0, UNPINNED);
      end
    end

    push <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Summary: %0d samples over %0d register settings, %0d results checked, %0d mismatches",
             samples_sent, settings_applied, results_checked, mismatches);
    $display("Rules hit (none, i..vi): %0d %0d %0d %0d %0d %0d %0d", rule_hits[0], rule_hits[1],
             rule_hits[2], rule_hits[3], rule_hits[4], rule_hits[5], rule_hits[6]);
    if (mismatches == 0) begin
      $display("tb_inverter_hybrid_band_control passed");
    end else begin
      $display("tb_inverter_hybrid_band_control failed");
    end
    $finish;
  end

endmodule

>>> inverter_hybrid_band_control.f
hdl/ihbc_pkg.sv
hdl/ihbc_front.sv
hdl/ihbc_queue.sv
hdl/ihbc_back.sv
hdl/inverter_hybrid_band_control.sv
sim/tb_inverter_hybrid_band_control.sv
